@@ rtl/core/llirm_pkg.sv @@
package llirm_pkg;

  // Item and register widths
  localparam int SAMPLE_BITS  = 16;
  localparam int ADDR_FIELD_W = 16;
  localparam int FRAC_BITS    = 16;
  localparam int LEN_W        = 17;
  localparam int POS_W        = LEN_W + FRAC_BITS;
  localparam int RATE_W       = 20;
  localparam int MODE_W       = 2;
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 20;
  localparam int IN_TDATA_W   = ADDR_FIELD_W + 3 * SAMPLE_BITS;
  localparam int OUT_TDATA_W  = 2 * SAMPLE_BITS;

  localparam int CLIP_DEPTH_DEF = 65536;

  // Clip gain of 0.7 in Q15
  localparam int                     GAIN_W    = 16;
  localparam int                     GAIN_FRAC = 15;
  localparam logic signed [GAIN_W-1:0] GAIN_Q15 = 16'sd22938;

  localparam logic [RATE_W-1:0] RATE_STEP_RST = 20'h10000;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_CLIP_LENGTH = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_RATE_STEP   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_PLAY_ENABLE = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_RENDER = 2'd1,
    MODE_REWIND = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_GAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rewind;
    logic start;
    logic fetch;
    logic mul;
    logic gain;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              active;
    logic              out_free;
  } sts_t;

endpackage

@@ rtl/core/llirm_ctrl.sv @@
module llirm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  llirm_pkg::sts_t   sts,
  output llirm_pkg::cmd_t   cmd
);

  llirm_pkg::state_t state_r;
  llirm_pkg::state_t state_nxt;
  llirm_pkg::state_t after_take;
  logic              take;

  assign in_tready = (state_r == llirm_pkg::ST_IDLE) ||
                     ((state_r == llirm_pkg::ST_OUT) && sts.out_free);
  assign take      = in_tvalid && in_tready;

  // Only a render leaves idle; a dry render skips straight to the output
  always_comb begin
    after_take = llirm_pkg::ST_IDLE;
    if (sts.mode == llirm_pkg::MODE_RENDER) begin
      after_take = sts.active ? llirm_pkg::ST_FETCH : llirm_pkg::ST_OUT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      llirm_pkg::ST_IDLE: begin
        if (take) begin
          state_nxt = after_take;
        end
      end
      llirm_pkg::ST_FETCH: state_nxt = llirm_pkg::ST_MUL;
      llirm_pkg::ST_MUL:   state_nxt = llirm_pkg::ST_GAIN;
      llirm_pkg::ST_GAIN:  state_nxt = llirm_pkg::ST_OUT;
      llirm_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = take ? after_take : llirm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = llirm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = take && (sts.mode == llirm_pkg::MODE_LOAD);
    cmd.rewind = take && (sts.mode == llirm_pkg::MODE_REWIND);
    cmd.start  = take && (sts.mode == llirm_pkg::MODE_RENDER);
    unique case (state_r)
      llirm_pkg::ST_IDLE:  ;
      llirm_pkg::ST_FETCH: cmd.fetch = 1'b1;
      llirm_pkg::ST_MUL:   cmd.mul   = 1'b1;
      llirm_pkg::ST_GAIN:  cmd.gain  = 1'b1;
      llirm_pkg::ST_OUT:   cmd.emit  = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llirm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/llirm_dp.sv @@
module llirm_dp #(
  parameter int CLIP_DEPTH = llirm_pkg::CLIP_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [llirm_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [llirm_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic [llirm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [llirm_pkg::MODE_W-1:0]         in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [llirm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tuser,
  input  llirm_pkg::cmd_t                      cmd,
  output llirm_pkg::sts_t                      sts
);

  localparam int AW  = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int SB  = llirm_pkg::SAMPLE_BITS;
  localparam int FB  = llirm_pkg::FRAC_BITS;
  localparam int LW  = llirm_pkg::LEN_W;
  localparam int PW  = llirm_pkg::POS_W;
  localparam int RW  = llirm_pkg::RATE_W;
  localparam int ADW = llirm_pkg::ADDR_FIELD_W;
  localparam int VW  = SB + FB + 2;
  localparam int GPW = VW + llirm_pkg::GAIN_W;
  localparam int SH  = llirm_pkg::GAIN_FRAC + FB;
  localparam logic [GPW-1:0] RND = GPW'(1) << (SH - 1);
  localparam logic signed [SB+1:0] SMAX = (SB + 2)'((1 << (SB - 1)) - 1);
  localparam logic signed [SB+1:0] SMIN = ~SMAX;

  // Input item fields
  logic [ADW-1:0]       load_address;
  logic signed [SB-1:0] load_sample;
  logic signed [SB-1:0] dry_left;
  logic signed [SB-1:0] dry_right;

  assign load_address = in_tdata[ADW-1:0];
  assign load_sample  = in_tdata[ADW+SB-1:ADW];
  assign dry_left     = in_tdata[ADW+2*SB-1:ADW+SB];
  assign dry_right    = in_tdata[ADW+3*SB-1:ADW+2*SB];

  // Configuration
  logic [LW-1:0] clip_length_r;
  logic [RW-1:0] rate_step_r;
  logic          play_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_length_r <= '0;
      rate_step_r   <= llirm_pkg::RATE_STEP_RST;
      play_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        llirm_pkg::CFG_CLIP_LENGTH: clip_length_r <= cfg_wdata[LW-1:0];
        llirm_pkg::CFG_RATE_STEP:   rate_step_r   <= cfg_wdata[RW-1:0];
        llirm_pkg::CFG_PLAY_ENABLE: play_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Play position and neighbour indexes
  logic [PW-1:0] pos_r;
  logic [LW-1:0] len_eff;
  logic          active;
  logic          wrap;
  logic [PW-1:0] base_pos;
  logic [LW-1:0] i0;
  logic [LW:0]   i1_inc;
  logic [LW-1:0] i1;
  logic [PW-1:0] pos_adv;

  always_comb begin
    len_eff  = (32'(clip_length_r) > 32'(CLIP_DEPTH)) ? LW'(CLIP_DEPTH) : clip_length_r;
    active   = play_enable_r && (len_eff != '0);
    wrap     = pos_r[PW-1:FB] >= len_eff;
    base_pos = wrap ? '0 : pos_r;
    i0       = base_pos[PW-1:FB];
    i1_inc   = {1'b0, i0} + (LW + 1)'(1);
    i1       = (i1_inc >= {1'b0, len_eff}) ? '0 : i1_inc[LW-1:0];
    pos_adv  = base_pos + PW'(rate_step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.rewind) begin
      pos_r <= '0;
    end else if (cmd.start && active) begin
      pos_r <= pos_adv;
    end
  end

  // Clip store: one write port and one read port
  logic signed [SB-1:0] clip_store [CLIP_DEPTH];
  logic signed [SB-1:0] rd_data_r;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [LW-1:0]        i1_r;

  assign wr_en   = cmd.load && (32'(load_address) < 32'(CLIP_DEPTH));
  assign wr_addr = AW'(load_address);
  assign rd_addr = cmd.fetch ? AW'(i1_r) : AW'(i0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      clip_store[wr_addr] <= load_sample;
    end
    rd_data_r <= clip_store[rd_addr];
  end

  // Per-item registers
  logic signed [SB-1:0] dry_l_r;
  logic signed [SB-1:0] dry_r_r;
  logic [FB-1:0]        f_r;
  logic                 looped_r;
  logic                 mix_r;
  logic signed [SB-1:0] s0_r;
  logic signed [VW-1:0] v_r;
  logic signed [SB:0]   add_r;

  // Interpolation: s0 * 2^16 + (s1 - s0) * f
  logic signed [SB:0]    diff;
  logic signed [VW-1:0]  base;
  logic signed [VW-1:0]  prod;
  logic signed [GPW-1:0] g_prod;
  logic signed [GPW-1:0] g_rnd;

  always_comb begin
    diff   = {rd_data_r[SB-1], rd_data_r} - {s0_r[SB-1], s0_r};
    base   = $signed({{2{s0_r[SB-1]}}, s0_r, {FB{1'b0}}});
    prod   = diff * $signed({1'b0, f_r});
    g_prod = v_r * llirm_pkg::GAIN_Q15;
    g_rnd  = g_prod + $signed(RND);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dry_l_r  <= dry_left;
      dry_r_r  <= dry_right;
      i1_r     <= i1;
      f_r      <= base_pos[FB-1:0];
      looped_r <= active && wrap;
      mix_r    <= active;
    end
    if (cmd.fetch) begin
      s0_r <= rd_data_r;
    end
    if (cmd.mul) begin
      v_r <= base + prod;
    end
    if (cmd.gain) begin
      // floor of the rounded product: drop the low bits
      add_r <= g_rnd[SH+SB:SH];
    end
  end

  // Mix and saturate
  function automatic logic [SB-1:0] sat_sample(input logic signed [SB+1:0] x);
    logic [SB-1:0] res;
    if (x > SMAX) begin
      res = SMAX[SB-1:0];
    end else if (x < SMIN) begin
      res = SMIN[SB-1:0];
    end else begin
      res = x[SB-1:0];
    end
    return res;
  endfunction

  logic signed [SB+1:0] clip_add;
  logic signed [SB+1:0] sum_l;
  logic signed [SB+1:0] sum_r;

  always_comb begin
    clip_add = mix_r ? {add_r[SB], add_r} : '0;
    sum_l    = {{2{dry_l_r[SB-1]}}, dry_l_r} + clip_add;
    sum_r    = {{2{dry_r_r[SB-1]}}, dry_r_r} + clip_add;
  end

  // Output register
  logic                                 out_tvalid_r;
  logic                                 out_tvalid_nxt;
  logic [llirm_pkg::OUT_TDATA_W-1:0]    out_tdata_r;
  logic                                 out_tuser_r;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {sat_sample(sum_r), sat_sample(sum_l)};
      out_tuser_r <= looped_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    sts          = '0;
    sts.mode     = in_tuser;
    sts.active   = active;
    sts.out_free = !out_tvalid_r || out_tready;
  end

endmodule

@@ rtl/core/looping_linear_interp_resample_mixer.sv @@
// Looping clip player: mixes a stored mono clip, resampled by linear
// interpolation, into a stereo stream.
// Input channel in_*: tuser holds the item kind (load a clip sample, render
// one stereo frame, rewind the play position). Load, rewind and unused kinds
// give no result and leave the input ready. A render gives exactly one result
// on out_*, carrying the mixed frame and a flag that the clip restarted.
// With playback on and a nonzero clip length a render steps through FETCH,
// MUL, GAIN and OUT before its result reaches the output register; otherwise
// the dry frame goes straight to OUT. A mixing render holds the input until
// it reaches OUT: the clip memory's single read port serves the frame's two
// sample reads in turn, then the interpolation and gain multiplies follow.
// Dry renders, loads and rewinds go one per cycle while out_* is not stalled.
// A new item is accepted in the cycle a result is written to the output
// register, so a waiting result does not hold up the input side; when the
// receiver stalls with the output register full, a finished render waits
// and in_tready drops until the register frees.
// Reset (rst_n low, synchronous) clears the play position, the registers
// (clip_length 0, rate_step 1.0, playback off) and the output valid. The
// clip memory is not cleared: samples must be loaded before they are played.
// Configuration must be written through cfg_* with no item in flight (not checked).
module looping_linear_interp_resample_mixer #(
  parameter int CLIP_DEPTH = llirm_pkg::CLIP_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [llirm_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [llirm_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // load_address, load_sample, dry_left, dry_right
  input  logic [llirm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode
  input  logic [llirm_pkg::MODE_W-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // mixed_left, mixed_right
  output logic [llirm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // looped
  output logic                               out_tuser
);

  llirm_pkg::cmd_t cmd;
  llirm_pkg::sts_t sts;

  llirm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  llirm_dp #(
    .CLIP_DEPTH (CLIP_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ rtl/core/llirm_chk.sv @@
module llirm_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [llirm_pkg::MODE_W-1:0]       in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [llirm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                               out_tuser
);

  // Reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid survived reset");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Load, rewind and unused kinds finish in the cycle they are taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != llirm_pkg::MODE_RENDER) |=> in_tready)
    else $error("non-render item held the input");

  // A fresh result comes from an earlier accepted render, dry or mixing
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      $past(in_tvalid && in_tready && (in_tuser == llirm_pkg::MODE_RENDER), 2) ||
      $past(in_tvalid && in_tready && (in_tuser == llirm_pkg::MODE_RENDER), 5))
    else $error("result without a matching render");

endmodule

bind looping_linear_interp_resample_mixer llirm_chk u_llirm_chk (.*);

@@ tb/looping_linear_interp_resample_mixer_tb.sv @@
module looping_linear_interp_resample_mixer_tb;
  import llirm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int FILL_DEPTH   = 64;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mixed_left;
    logic signed [SAMPLE_BITS-1:0] mixed_right;
    logic                          looped;
  } mixed_frame_t;

  // Tracks the clip store, play position and registers; queues the frames that
  // renders are due to produce and checks them in order.
  class clip_mix_model;
    logic signed [SAMPLE_BITS-1:0] clip_mem [CLIP_DEPTH_DEF];
    logic [POS_W-1:0]              position;
    logic [LEN_W-1:0]              clip_len;
    logic [RATE_W-1:0]             rate;
    logic                          play_on;
    mixed_frame_t                  expected_frames [$];
    int                            fail_count;

    function new();
      position   = '0;
      clip_len   = '0;
      rate       = 20'h10000;
      play_on    = 1'b0;
      fail_count = 0;
    endfunction

    function void set_config(logic [LEN_W-1:0] len, logic [RATE_W-1:0] step, logic en);
      clip_len = len;
      rate     = step;
      play_on  = en;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function longint clamp_sample(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
    endfunction

    function void note_item(logic [MODE_W-1:0] mode_bits, logic [IN_TDATA_W-1:0] data);
      mixed_frame_t      fr;
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  i0;
      logic [LEN_W-1:0]  i1;
      logic [FRAC_BITS-1:0] frac;
      longint            s0, s1, v, clip_add, l, r;
      mode_t             mode;
      mode = mode_t'(mode_bits);
      case (mode)
        MODE_LOAD: clip_mem[data[15:0]] = data[31:16];
        MODE_REWIND: position = '0;
        MODE_RENDER: begin
          l = $signed(data[47:32]);
          r = $signed(data[63:48]);
          fr.looped = 1'b0;
          len = (clip_len > LEN_W'(CLIP_DEPTH_DEF)) ? LEN_W'(CLIP_DEPTH_DEF) : clip_len;
          if (play_on && len != 0) begin
            i0   = position[POS_W-1:FRAC_BITS];
            frac = position[FRAC_BITS-1:0];
            // restart when the position has run off the end of the clip
            if (i0 >= len) begin
              position  = '0;
              i0        = '0;
              frac      = '0;
              fr.looped = 1'b1;
            end
            i1 = i0 + 1'b1;
            if (i1 >= len) i1 = '0;
            s0 = clip_mem[i0[15:0]];
            s1 = clip_mem[i1[15:0]];
            v  = s0 * 65536 + (s1 - s0) * longint'(frac);
            // round to nearest, ties upward; >>> on a signed value floors
            clip_add = (v * longint'(GAIN_Q15) + (longint'(1) << 30)) >>> 31;
            l = clamp_sample(l + clip_add);
            r = clamp_sample(r + clip_add);
            position = position + POS_W'(rate);
          end
          fr.mixed_left  = l[SAMPLE_BITS-1:0];
          fr.mixed_right = r[SAMPLE_BITS-1:0];
          expected_frames = {expected_frames, fr};
        end
        default: ;
      endcase
    endfunction

    function void check_frame(logic [OUT_TDATA_W-1:0] data, logic looped);
      mixed_frame_t fr;
      if (expected_frames.size() == 0) begin
        $error("result item with no render pending: tdata %h tuser %b", data, looped);
        fail_count++;
        return;
      end
      fr = expected_frames.pop_front();
      if (data[15:0] !== fr.mixed_left) begin
        $error("mixed_left: expected %0d, got %0d", fr.mixed_left, $signed(data[15:0]));
        fail_count++;
      end
      if (data[31:16] !== fr.mixed_right) begin
        $error("mixed_right: expected %0d, got %0d", fr.mixed_right, $signed(data[31:16]));
        fail_count++;
      end
      if (looped !== fr.looped) begin
        $error("looped: expected %0d, got %0d", fr.looped, looped);
        fail_count++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [CFG_DW-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  clip_mix_model mix_model = new();
  int            in_idle_pct;
  int            stall_pct;
  int            quiet_cycles;

  looping_linear_interp_resample_mixer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) mix_model.check_frame(out_tdata, out_tuser);
      if (in_tvalid && in_tready) mix_model.note_item(in_tuser, in_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: hold ready low for short bursts when stalling is on
  initial begin
    forever begin
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(logic [15:0] addr, logic [15:0] sample,
                                                      logic [15:0] left, logic [15:0] right);
    return {right, left, sample, addr};
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] mode_bits,
                           input logic [IN_TDATA_W-1:0] data);
    logic taken;
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode_bits;
    in_tdata  <= data;
    // sample ready mid-cycle, where it holds its value for the coming edge
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
  endtask

  task automatic render_frame(input logic [15:0] left, input logic [15:0] right);
    send_item(MODE_RENDER, pack_item(16'($urandom), 16'($urandom), left, right));
  endtask

  task automatic load_clip(input logic [15:0] addr, input logic [15:0] sample);
    send_item(MODE_LOAD, pack_item(addr, sample, 16'($urandom), 16'($urandom)));
  endtask

  task automatic rewind();
    send_item(MODE_REWIND, {$urandom, $urandom});
  endtask

  // Drop valid, wait for every pending frame and let loads and rewinds retire
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (mix_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [LEN_W-1:0] len, input logic [RATE_W-1:0] step,
                           input logic en);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CLIP_LENGTH;
    cfg_wdata <= CFG_DW'(len);
    @(posedge clk);
    cfg_addr  <= CFG_RATE_STEP;
    cfg_wdata <= CFG_DW'(step);
    @(posedge clk);
    cfg_addr  <= CFG_PLAY_ENABLE;
    cfg_wdata <= CFG_DW'(en);
    @(posedge clk);
    cfg_we    <= 1'b0;
    mix_model.set_config(len, step, en);
  endtask

  initial begin
    int               pick;
    logic [15:0]      addr;
    logic [LEN_W-1:0] len;
    logic [RATE_W-1:0] step;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_addr    <= '0;
    cfg_wdata   <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    in_idle_pct = 25;
    stall_pct   = 25;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the low part of the store; every render below reads only there
    for (int a = 0; a < FILL_DEPTH; a++) load_clip(16'(a), 16'($urandom));

    // Four-sample clip at rate 1.5: saturation both ways, wrap of the
    // neighbour at the clip end, loop back to zero, unused mode
    configure(LEN_W'(4), 20'h18000, 1'b1);
    load_clip(16'd0, 16'h7FFF);
    load_clip(16'd1, 16'h8000);
    load_clip(16'd2, 16'h0000);
    load_clip(16'd3, 16'hFFFF);
    rewind();
    render_frame(16'h7FFF, 16'h7FFF);
    render_frame(16'h8000, 16'h8000);
    render_frame(16'h0000, 16'h0000);
    render_frame(16'd100, -16'sd100);
    send_item(MODE_UNUSED, {$urandom, $urandom});
    render_frame(16'h8000, 16'h7FFF);
    rewind();
    render_frame(16'h0123, 16'hFEDC);

    // Shorten the clip under a position already past its new end
    configure(LEN_W'(16), 20'h30000, 1'b1);
    rewind();
    repeat (4) render_frame(rand_sample(), rand_sample());
    configure(LEN_W'(5), 20'h30000, 1'b1);
    repeat (2) render_frame(rand_sample(), rand_sample());

    // Zero rate holds, disabled playback and an empty clip pass dry audio
    configure(LEN_W'(5), 20'h00000, 1'b1);
    repeat (2) render_frame(rand_sample(), rand_sample());
    configure(LEN_W'(5), 20'h10000, 1'b0);
    repeat (2) render_frame(16'h7FFF, 16'h8000);
    configure('0, 20'h10000, 1'b1);
    repeat (2) render_frame(rand_sample(), rand_sample());

    // A length above the store depth acts as the full store
    configure(17'h1FFFF, 20'h0C000, 1'b1);
    rewind();
    repeat (4) render_frame(rand_sample(), rand_sample());

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = LEN_W'(1);
        2: len = LEN_W'(2);
        3: len = 17'h1FFFF;
        default: len = LEN_W'($urandom_range(1, FILL_DEPTH));
      endcase
      case ($urandom_range(0, 7))
        0: step = 20'h00000;
        1: step = 20'hFFFFF;
        2: step = 20'h10000;
        default: step = RATE_W'($urandom_range(1, 20'h4FFFF));
      endcase
      // keep a long clip's reads inside the filled samples
      if (len > LEN_W'(FILL_DEPTH)) step = RATE_W'($urandom_range(0, 20'h08000));
      configure(len, step, $urandom_range(0, 5) != 0);
      if (len > LEN_W'(FILL_DEPTH)) rewind();
      // quiet on both sides for the closing phase
      in_idle_pct = (ph == 5) ? 0 : 20 * $urandom_range(0, 2);
      stall_pct   = (ph == 5) ? 0 : 20 * $urandom_range(0, 2);
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          render_frame(rand_sample(), rand_sample());
        end else if (pick < 85) begin
          addr = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 63)) : 16'($urandom);
          load_clip(addr, rand_sample());
        end else if (pick < 95) begin
          rewind();
        end else begin
          send_item(MODE_UNUSED, {$urandom, $urandom});
        end
      end
    end

    settle();
    if (mix_model.fail_count == 0 && mix_model.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
